/* rtl/ldt_pkg.sv */
package ldt_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int LAYERS_DEF   = 5;

	localparam int ID_W    = 16;
	localparam int LAYER_W = 3;
	localparam int ORDER_W = 16;
	localparam int MODE_W  = 2;
	localparam int STAT_W  = 2;
	localparam int ENTRY_W = ID_W + LAYER_W + ORDER_W;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD     = 2'd0,
		MODE_REMOVE  = 2'd1,
		MODE_REORDER = 2'd2,
		MODE_DRAIN   = 2'd3
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_INS_ZERO,
		S_REM,
		S_REKEY,
		S_DRAIN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]           id;
		logic [LAYER_W-1:0]        layer;
		logic signed [ORDER_W-1:0] order;
	} entry_t;

	// one result beat handed from the sequencer to the output register
	typedef struct packed {
		logic                      valid;
		logic [ID_W-1:0]           id;
		logic [LAYER_W-1:0]        layer;
		logic signed [ORDER_W-1:0] order;
		status_t                   status;
		logic                      last;
	} emit_t;

endpackage

/* rtl/ldt_req_if.sv */
interface ldt_req_if;
	logic                              valid;
	logic                              ready;
	logic [ldt_pkg::MODE_W-1:0]        mode;
	logic [ldt_pkg::ID_W-1:0]          entry_id;
	logic [ldt_pkg::LAYER_W-1:0]       entry_layer;
	logic signed [ldt_pkg::ORDER_W-1:0] entry_order;

	modport source (output valid, mode, entry_id, entry_layer, entry_order, input ready);
	modport sink (input valid, mode, entry_id, entry_layer, entry_order, output ready);
endinterface

/* rtl/ldt_rsp_if.sv */
interface ldt_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [ldt_pkg::ID_W-1:0]          out_id;
	logic [ldt_pkg::LAYER_W-1:0]       out_layer;
	logic signed [ldt_pkg::ORDER_W-1:0] out_order;
	logic [ldt_pkg::STAT_W-1:0]        status;
	logic                              last;

	modport source (output valid, out_id, out_layer, out_order, status, last, input ready);
	modport sink (input valid, out_id, out_layer, out_order, status, last, output ready);
endinterface

/* rtl/layered_sorted_draw_table.sv */
// layered sorted draw table
// keeps up to CAPACITY entries (id, layer, signed order) sorted by layer, then
// order; equal keys stay in arrival order, a new entry lands after its equals
// req channel: one beat per request, mode 0 add, 1 remove, 2 change order,
// 3 drain; req.ready is high only while the sequencer is idle
// rsp channel: add, remove and change order answer with one beat (last = 1);
// drain sends one beat per entry in draw order, last on the final one, or a
// single empty-status beat when the table holds nothing
// work per request: add makes one pass from the tail that finds the slot and
// shifts in the same sweep; remove makes one sweep over the held entries;
// change order runs a remove sweep, then an insert sweep; drain sends one
// beat per cycle while the output register is free; req.ready is high again
// once the result sits in the output register; the table ram has one read
// and one write per cycle with a registered read
// a stalled receiver holds the output register; the sequencer waits on it
// and never drops or repeats a beat; a new request may be taken while the
// last result still sits unclaimed in the output register
// reset empties the table (count to zero); ram contents are not cleared
// and need no sweep, only the first count entries are ever read
module layered_sorted_draw_table #(
	parameter int CAPACITY = ldt_pkg::CAPACITY_DEF,
	parameter int LAYERS   = ldt_pkg::LAYERS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	ldt_req_if.sink  req,
	ldt_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	ldt_pkg::emit_t  emit;
	logic            out_free;
	logic [AW-1:0]   rd_addr, wr_addr;
	logic            wr_en;
	ldt_pkg::entry_t rd_data, wr_data;

	// output register state
	logic                               out_valid_q;
	logic [ldt_pkg::ID_W-1:0]           out_id_q;
	logic [ldt_pkg::LAYER_W-1:0]        out_layer_q;
	logic signed [ldt_pkg::ORDER_W-1:0] out_order_q;
	logic [ldt_pkg::STAT_W-1:0]         status_q;
	logic                               last_q;

	ldt_ram #(
		.WIDTH (ldt_pkg::ENTRY_W),
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ldt_seq #(
		.CAPACITY (CAPACITY),
		.LAYERS   (LAYERS),
		.AW       (AW),
		.CW       (CW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.out_free (out_free),
		.emit     (emit),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	// register is free when empty or when its beat leaves this cycle
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload, loaded only with a new beat
	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_id_q    <= emit.id;
			out_layer_q <= emit.layer;
			out_order_q <= emit.order;
			status_q    <= emit.status;
			last_q      <= emit.last;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.out_id    = out_id_q;
	assign rsp.out_layer = out_layer_q;
	assign rsp.out_order = out_order_q;
	assign rsp.status    = status_q;
	assign rsp.last      = last_q;

endmodule

/* rtl/ldt_ram.sv */
module ldt_ram #(
	parameter int WIDTH = ldt_pkg::ENTRY_W,
	parameter int DEPTH = ldt_pkg::CAPACITY_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/ldt_cmp.sv */
module ldt_cmp (
	input  ldt_pkg::entry_t                   ent,
	input  logic [ldt_pkg::LAYER_W-1:0]       key_layer,
	input  logic signed [ldt_pkg::ORDER_W-1:0] key_order,
	input  logic [ldt_pkg::ID_W-1:0]          key_id,
	output logic                              gt,
	output logic                              hit
);

	// stored key strictly above the new key: the new entry goes before it
	assign gt  = (ent.layer > key_layer) ||
	             ((ent.layer == key_layer) && (ent.order > key_order));
	assign hit = (ent.id == key_id);

endmodule

/* rtl/ldt_seq.sv */
module ldt_seq #(
	parameter int CAPACITY = ldt_pkg::CAPACITY_DEF,
	parameter int LAYERS   = ldt_pkg::LAYERS_DEF,
	parameter int AW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	ldt_req_if.sink          req,
	input  logic             out_free,
	output ldt_pkg::emit_t   emit,
	output logic [AW-1:0]    rd_addr,
	input  ldt_pkg::entry_t  rd_data,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output ldt_pkg::entry_t  wr_data
);

	localparam logic [ldt_pkg::LAYER_W-1:0] TOP_LAYER = ldt_pkg::LAYER_W'(LAYERS - 1);

	ldt_pkg::state_t  state_q, state_d;
	ldt_pkg::mode_t   mode_q, req_mode;
	ldt_pkg::status_t status_q;
	logic [AW-1:0]    i_q, i_d;
	logic [CW-1:0]    count_q, cnt_m1;
	logic [ldt_pkg::ID_W-1:0]           id_q;
	logic [ldt_pkg::LAYER_W-1:0]        layer_q, sat_layer;
	logic signed [ldt_pkg::ORDER_W-1:0] order_q;
	logic             found_q;
	logic             accept, at_last, gt, hit;
	ldt_pkg::entry_t  new_ent;

	assign req.ready = (state_q == ldt_pkg::S_IDLE);
	assign accept    = req.valid && req.ready;
	assign req_mode  = ldt_pkg::mode_t'(req.mode);
	assign sat_layer = (req.entry_layer > TOP_LAYER) ? TOP_LAYER : req.entry_layer;
	assign cnt_m1    = count_q - CW'(1);
	assign at_last   = (CW'(i_q) == cnt_m1);
	assign new_ent   = '{id: id_q, layer: layer_q, order: order_q};
	assign rd_addr   = i_d;

	ldt_cmp u_cmp (
		.ent       (rd_data),
		.key_layer (layer_q),
		.key_order (order_q),
		.key_id    (id_q),
		.gt        (gt),
		.hit       (hit)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ldt_pkg::S_IDLE: begin
				if (accept) begin
					unique case (req_mode) inside
						ldt_pkg::MODE_ADD: begin
							if (count_q == CW'(CAPACITY)) state_d = ldt_pkg::S_RESP;
							else if (count_q == '0) state_d = ldt_pkg::S_INS_ZERO;
							else state_d = ldt_pkg::S_INS;
						end
						ldt_pkg::MODE_REMOVE, ldt_pkg::MODE_REORDER: begin
							state_d = (count_q == '0) ? ldt_pkg::S_RESP : ldt_pkg::S_REM;
						end
						default: begin
							state_d = (count_q == '0) ? ldt_pkg::S_RESP : ldt_pkg::S_DRAIN;
						end
					endcase
				end
			end
			ldt_pkg::S_INS: begin
				if (!gt) state_d = ldt_pkg::S_RESP;
				else if (i_q == '0) state_d = ldt_pkg::S_INS_ZERO;
			end
			ldt_pkg::S_INS_ZERO: state_d = ldt_pkg::S_RESP;
			ldt_pkg::S_REM: begin
				if (at_last) begin
					if ((found_q || hit) && (mode_q == ldt_pkg::MODE_REORDER))
						state_d = ldt_pkg::S_REKEY;
					else
						state_d = ldt_pkg::S_RESP;
				end
			end
			ldt_pkg::S_REKEY: begin
				state_d = (count_q == '0) ? ldt_pkg::S_INS_ZERO : ldt_pkg::S_INS;
			end
			ldt_pkg::S_DRAIN: begin
				if (out_free && at_last) state_d = ldt_pkg::S_IDLE;
			end
			ldt_pkg::S_RESP: begin
				if (out_free) state_d = ldt_pkg::S_IDLE;
			end
			default: state_d = ldt_pkg::S_IDLE;
		endcase
	end

	// memory port, scan index and result beat
	always_comb begin
		i_d     = i_q;
		wr_en   = 1'b0;
		wr_addr = i_q;
		wr_data = rd_data;
		emit    = '0;
		unique case (state_q)
			ldt_pkg::S_IDLE: begin
				if (accept) begin
					if (req_mode == ldt_pkg::MODE_ADD) i_d = cnt_m1[AW-1:0];
					else i_d = '0;
				end
			end
			ldt_pkg::S_INS: begin
				// walk down from the tail, moving larger keys up one slot
				wr_en   = 1'b1;
				wr_addr = i_q + AW'(1);
				if (gt) begin
					if (i_q != '0) i_d = i_q - AW'(1);
				end else begin
					wr_data = new_ent;
				end
			end
			ldt_pkg::S_INS_ZERO: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = new_ent;
			end
			ldt_pkg::S_REM: begin
				// after the match every entry slides down one slot
				if (found_q) begin
					wr_en   = 1'b1;
					wr_addr = i_q - AW'(1);
				end
				if (!at_last) i_d = i_q + AW'(1);
			end
			ldt_pkg::S_REKEY: begin
				i_d = cnt_m1[AW-1:0];
			end
			ldt_pkg::S_DRAIN: begin
				emit.valid  = out_free;
				emit.id     = rd_data.id;
				emit.layer  = rd_data.layer;
				emit.order  = rd_data.order;
				emit.status = ldt_pkg::ST_OK;
				emit.last   = at_last;
				if (out_free && !at_last) i_d = i_q + AW'(1);
			end
			ldt_pkg::S_RESP: begin
				emit.valid  = out_free;
				emit.id     = (status_q == ldt_pkg::ST_EMPTY) ? '0 : id_q;
				emit.status = status_q;
				emit.last   = 1'b1;
			end
			default: begin
				i_d = i_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ldt_pkg::S_IDLE;
			i_q      <= '0;
			count_q  <= '0;
			mode_q   <= ldt_pkg::MODE_ADD;
			status_q <= ldt_pkg::ST_OK;
			id_q     <= '0;
			layer_q  <= '0;
			order_q  <= '0;
			found_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			unique case (state_q)
				ldt_pkg::S_IDLE: begin
					if (accept) begin
						mode_q   <= req_mode;
						id_q     <= req.entry_id;
						layer_q  <= sat_layer;
						order_q  <= req.entry_order;
						found_q  <= 1'b0;
						status_q <= ldt_pkg::ST_OK;
						if (count_q == '0) begin
							unique case (req_mode) inside
								ldt_pkg::MODE_REMOVE, ldt_pkg::MODE_REORDER:
									status_q <= ldt_pkg::ST_NOT_FOUND;
								ldt_pkg::MODE_DRAIN: status_q <= ldt_pkg::ST_EMPTY;
								default: status_q <= ldt_pkg::ST_OK;
							endcase
						end else if (req_mode == ldt_pkg::MODE_ADD &&
						             count_q == CW'(CAPACITY)) begin
							status_q <= ldt_pkg::ST_FULL;
						end
					end
				end
				ldt_pkg::S_INS: begin
					if (!gt) count_q <= count_q + CW'(1);
				end
				ldt_pkg::S_INS_ZERO: count_q <= count_q + CW'(1);
				ldt_pkg::S_REM: begin
					if (!found_q && hit) begin
						found_q <= 1'b1;
						layer_q <= rd_data.layer;
					end
					if (at_last) begin
						if (found_q || hit) count_q <= cnt_m1;
						else status_q <= ldt_pkg::ST_NOT_FOUND;
					end
				end
				default: begin
					found_q <= found_q;
				end
			endcase
		end
	end

endmodule

/* verif/draw_order_checker.sv */
`timescale 1ns / 100ps

module draw_order_checker #(
	parameter int CAPACITY = ldt_pkg::CAPACITY_DEF,
	parameter int LAYERS   = ldt_pkg::LAYERS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ldt_req_if   req,
	ldt_rsp_if   rsp,
	output int   mismatches,
	output int   beats_due
);
	import ldt_pkg::*;

	typedef struct {
		logic [ID_W-1:0]           id;
		logic [LAYER_W-1:0]        layer;
		logic signed [ORDER_W-1:0] order;
		status_t                   status;
		logic                      last;
	} draw_beat_t;

	draw_beat_t expected_beats[$];

	// shadow of the sorted table, first held entries valid
	logic [ID_W-1:0]           tbl_id [CAPACITY];
	logic [LAYER_W-1:0]        tbl_layer [CAPACITY];
	logic signed [ORDER_W-1:0] tbl_order [CAPACITY];
	int                        held;

	function automatic void queue_beat(logic [ID_W-1:0] id, logic [LAYER_W-1:0] layer,
			logic signed [ORDER_W-1:0] order, status_t status, logic last);
		draw_beat_t b;
		b.id     = id;
		b.layer  = layer;
		b.order  = order;
		b.status = status;
		b.last   = last;
		expected_beats.push_back(b);
	endfunction

	// lands after every entry whose key is not greater
	function automatic void insert_entry(logic [ID_W-1:0] id, logic [LAYER_W-1:0] layer,
			logic signed [ORDER_W-1:0] order);
		int slot;
		slot = 0;
		while (slot < held && (tbl_layer[slot] < layer ||
				(tbl_layer[slot] == layer && tbl_order[slot] <= order)))
			slot++;
		for (int i = held; i > slot; i--) begin
			tbl_id[i]    = tbl_id[i-1];
			tbl_layer[i] = tbl_layer[i-1];
			tbl_order[i] = tbl_order[i-1];
		end
		tbl_id[slot]    = id;
		tbl_layer[slot] = layer;
		tbl_order[slot] = order;
		held++;
	endfunction

	function automatic void delete_entry(int slot);
		for (int i = slot; i + 1 < held; i++) begin
			tbl_id[i]    = tbl_id[i+1];
			tbl_layer[i] = tbl_layer[i+1];
			tbl_order[i] = tbl_order[i+1];
		end
		held--;
	endfunction

	function automatic int first_with_id(logic [ID_W-1:0] id);
		for (int i = 0; i < held; i++)
			if (tbl_id[i] == id)
				return i;
		return held;
	endfunction

	function automatic void predict_request(mode_t mode, logic [ID_W-1:0] id,
			logic [LAYER_W-1:0] layer_in, logic signed [ORDER_W-1:0] order);
		logic [LAYER_W-1:0] layer;
		logic [LAYER_W-1:0] kept_layer;
		int                 slot;
		layer = (int'(layer_in) > LAYERS - 1) ? LAYER_W'(LAYERS - 1) : layer_in;
		case (mode)
			MODE_ADD: begin
				if (held >= CAPACITY) begin
					queue_beat(id, '0, '0, ST_FULL, 1'b1);
				end else begin
					insert_entry(id, layer, order);
					queue_beat(id, '0, '0, ST_OK, 1'b1);
				end
			end
			MODE_REMOVE, MODE_REORDER: begin
				slot = first_with_id(id);
				if (slot >= held) begin
					queue_beat(id, '0, '0, ST_NOT_FOUND, 1'b1);
				end else begin
					kept_layer = tbl_layer[slot];
					delete_entry(slot);
					if (mode == MODE_REORDER)
						insert_entry(id, kept_layer, order);
					queue_beat(id, '0, '0, ST_OK, 1'b1);
				end
			end
			default: begin
				if (held == 0) begin
					queue_beat('0, '0, '0, ST_EMPTY, 1'b1);
				end else begin
					for (int i = 0; i < held; i++)
						queue_beat(tbl_id[i], tbl_layer[i], tbl_order[i], ST_OK,
							(i == held - 1));
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		draw_beat_t want;
		if (!arst_n) begin
			held = 0;
			expected_beats.delete();
		end else begin
			// response first: a beat never belongs to a request taken at the same edge
			if (rsp.valid && rsp.ready) begin
				if (expected_beats.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected beat, expected none, actual id %h layer %0d",
						$time, rsp.out_id, rsp.out_layer);
					$display("    order %0d status %0d last %0b",
						rsp.out_order, rsp.status, rsp.last);
				end else begin
					want = expected_beats.pop_front();
					if (rsp.out_id !== want.id || rsp.out_layer !== want.layer ||
							rsp.out_order !== want.order || rsp.status !== want.status ||
							rsp.last !== want.last) begin
						mismatches++;
						$display("%0t: beat mismatch, expected id %h layer %0d order %0d",
							$time, want.id, want.layer, want.order);
						$display("    status %0d last %0b, actual id %h layer %0d order %0d",
							want.status, want.last, rsp.out_id, rsp.out_layer,
							rsp.out_order);
						$display("    status %0d last %0b", rsp.status, rsp.last);
					end
				end
			end
			if (req.valid && req.ready)
				predict_request(mode_t'(req.mode), req.entry_id, req.entry_layer,
					req.entry_order);
		end
		beats_due = expected_beats.size();
	end

endmodule

/* verif/layered_sorted_draw_table_tb.sv */
`timescale 1ns / 100ps

module layered_sorted_draw_table_tb;
	import ldt_pkg::*;

	localparam int CAPACITY      = ldt_pkg::CAPACITY_DEF;
	localparam int LAYERS        = ldt_pkg::LAYERS_DEF;
	localparam int RANDOM_ITEMS  = 300;
	localparam int HOLD_AT       = 70;   // receiver goes deaf here
	localparam int PAUSE_AT      = 190;  // sender lets the table go quiet here
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 40;
	// slowest gap between two beats: a receiver stall, a change order and a
	// sender gap, or the long hold; the limit sits several times above the
	// longest of these
	localparam int STALL_LIMIT   = 3000;

	typedef enum int {
		PH_FILL,
		PH_CHURN,
		PH_SHRINK
	} phase_t;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   beats_due;
	int   quiet_cycles;
	bit   calm_req;
	bit   calm_rsp;
	bit   stall_receiver;

	// ids believed to sit in the table, used to aim removes and re-keys
	logic [ID_W-1:0] live_ids[$];

	ldt_req_if req_ch ();
	ldt_rsp_if rsp_ch ();

	layered_sorted_draw_table #(
		.CAPACITY(CAPACITY),
		.LAYERS(LAYERS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	draw_order_checker #(
		.CAPACITY(CAPACITY),
		.LAYERS(LAYERS)
	) draw_check (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.mismatches(mismatch_count),
		.beats_due(beats_due)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// one request beat: optional gap, then hold valid until the block takes it
	// valid stays high on return so back-to-back beats need no toggle
	task automatic offer(input mode_t mode, input logic [ID_W-1:0] id,
			input logic [LAYER_W-1:0] layer, input logic signed [ORDER_W-1:0] order);
		int gap;
		gap = calm_req ? 0 : $urandom_range(0, 14);
		if ($urandom_range(0, 24) == 0)
			calm_req = !calm_req;
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid       = 1'b1;
		req_ch.mode        = mode;
		req_ch.entry_id    = id;
		req_ch.entry_layer = layer;
		req_ch.entry_order = order;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// drain shows up in every phase so the sorted order is read back often
	function automatic mode_t pick_mode(phase_t phase);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			return MODE_DRAIN;
		case (phase)
			PH_FILL: begin
				if (roll < 95) return MODE_ADD;
				else if (roll < 98) return MODE_REORDER;
				else return MODE_REMOVE;
			end
			PH_CHURN: begin
				if (roll < 50) return MODE_ADD;
				else if (roll < 75) return MODE_REMOVE;
				else return MODE_REORDER;
			end
			default: begin
				if (roll < 25) return MODE_ADD;
				else if (roll < 75) return MODE_REMOVE;
				else return MODE_REORDER;
			end
		endcase
	endfunction

	task automatic random_item(input phase_t phase);
		mode_t                     mode;
		logic [ID_W-1:0]           id;
		logic [LAYER_W-1:0]        layer;
		logic signed [ORDER_W-1:0] order;
		int                        pick;
		mode = pick_mode(phase);
		// mostly legal layers, now and then one that saturates
		if ($urandom_range(0, 4) == 0)
			layer = LAYER_W'($urandom_range(LAYERS, 7));
		else
			layer = LAYER_W'($urandom_range(0, LAYERS - 1));
		// tight order band makes equal keys common, so arrival order matters
		case ($urandom_range(0, 4))
			0, 1: order = ORDER_W'(int'($urandom_range(0, 6)) - 3);
			2, 3: order = ORDER_W'($urandom);
			default: begin
				case ($urandom_range(0, 3))
					0: order = 16'sh8000;
					1: order = 16'sh7fff;
					2: order = 16'sh0000;
					default: order = 16'shffff;
				endcase
			end
		endcase
		if ((mode == MODE_REMOVE || mode == MODE_REORDER) && live_ids.size() > 0 &&
				$urandom_range(0, 3) != 0) begin
			pick = $urandom_range(0, live_ids.size() - 1);
			id   = live_ids[pick];
			if (mode == MODE_REMOVE)
				live_ids.delete(pick);
		end else if ($urandom_range(0, 9) < 7) begin
			// small id space so duplicates turn up
			id = ID_W'($urandom_range(0, 47));
		end else begin
			id = ID_W'($urandom);
		end
		if (mode == MODE_ADD && live_ids.size() < CAPACITY)
			live_ids.push_back(id);
		offer(mode, id, layer, order);
	endtask

	// receiver: random stall per beat, one long deaf stretch on request
	initial begin
		int gap;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (stall_receiver) begin
				// table keeps taking requests until the output register backs up
				rsp_ch.ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				stall_receiver = 1'b0;
			end
			gap = calm_rsp ? 0 : $urandom_range(0, 14);
			if ($urandom_range(0, 24) == 0)
				calm_rsp = !calm_rsp;
			if (gap > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			@(negedge clk);
		end
	end

	// watchdog: any beat on either side resets the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		phase_t phase;
		int     phase_left;
		req_ch.valid       = 1'b0;
		req_ch.mode        = MODE_ADD;
		req_ch.entry_id    = '0;
		req_ch.entry_layer = '0;
		req_ch.entry_order = '0;
		arst_n             = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// empty table: drain reports empty, remove and re-key miss
		offer(MODE_DRAIN, 16'h0000, 3'd0, 16'sd0);
		offer(MODE_REMOVE, 16'h0042, 3'd0, 16'sd0);
		offer(MODE_REORDER, 16'h0042, 3'd0, 16'sd0);
		// extreme ids, layers and orders; layer 7 and 5 saturate to the top layer
		offer(MODE_ADD, 16'h0000, 3'd0, 16'sh8000);
		offer(MODE_ADD, 16'hffff, 3'd7, 16'sh7fff);
		offer(MODE_ADD, 16'h0101, 3'd4, 16'sd0);
		offer(MODE_ADD, 16'h0202, 3'd5, 16'sd0);
		// equal keys keep arrival order
		offer(MODE_ADD, 16'h0303, 3'd2, 16'sd5);
		offer(MODE_ADD, 16'h0404, 3'd2, 16'sd5);
		// duplicate id that sorts ahead of the first copy
		offer(MODE_ADD, 16'h0303, 3'd1, -16'sd1);
		offer(MODE_DRAIN, 16'h0000, 3'd0, 16'sd0);
		// remove hits the first copy in draw order
		offer(MODE_REMOVE, 16'h0303, 3'd0, 16'sd0);
		offer(MODE_ADD, 16'h0505, 3'd2, 16'sd5);
		// re-key to the same order still moves behind its equals
		offer(MODE_REORDER, 16'h0303, 3'd6, 16'sd5);
		offer(MODE_REORDER, 16'hffff, 3'd0, 16'sh8000);
		offer(MODE_DRAIN, 16'h0000, 3'd0, 16'sd0);
		offer(MODE_REMOVE, 16'h0000, 3'd0, 16'sd0);
		offer(MODE_REMOVE, 16'h0000, 3'd0, 16'sd0);
		offer(MODE_REORDER, 16'h0404, 3'd3, 16'sh7fff);
		offer(MODE_DRAIN, 16'h0000, 3'd0, 16'sd0);

		// random part: opens with a fill phase so the full case is reached
		phase      = PH_FILL;
		phase_left = 50;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				phase      = phase_t'($urandom_range(0, 2));
				phase_left = $urandom_range(20, 50);
			end
			phase_left--;
			if (n == HOLD_AT)
				stall_receiver = 1'b1;
			if (n == PAUSE_AT) begin
				// sender goes quiet until the last expected beat is out
				req_ch.valid = 1'b0;
				wait (beats_due == 0);
				@(negedge clk);
			end
			random_item(phase);
		end
		req_ch.valid = 1'b0;

		wait (beats_due == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && beats_due == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
